FILE: sv/lgsc_pkg.sv
// ----------------------------------------------------------------------------
// lgsc_pkg
// Shared types and codes for the glyph slot cache: operation codes, sequencer
// states, the slot entry layout and the search summary.
// ----------------------------------------------------------------------------
package lgsc_pkg;

    localparam int CODE_W  = 16;
    localparam int STAMP_W = 32;
    localparam int IDX_W   = 6;
    localparam int OUT_W   = 24;

    typedef enum logic [1:0] {
        FUNC_GET    = 2'd0,
        FUNC_PROBE  = 2'd1,
        FUNC_REMOVE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [CODE_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic              found;
        logic              best_valid;
        logic [CODE_W-1:0] best_tag;
    } t_search;

endpackage

FILE: sv/lgsc_store.sv
// ----------------------------------------------------------------------------
// lgsc_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lgsc_store
    import lgsc_pkg::*;
#(
    parameter int SLOTS = 64,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lgsc_search.sv
// ----------------------------------------------------------------------------
// lgsc_search
// Shared compare unit: one tag compare and one stamp compare per cycle while
// i_en is high, tracking the first valid match and the first minimum stamp.
// ----------------------------------------------------------------------------
module lgsc_search
    import lgsc_pkg::*;
#(
    parameter int SLOTS = 64,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [AW-1:0]     i_idx,
    input  t_entry            i_entry,
    input  logic [CODE_W-1:0] i_code,
    output t_search           o_sum,
    output logic [AW-1:0]     o_match_idx,
    output logic [AW-1:0]     o_best_idx
);

    logic               r_found;
    logic [AW-1:0]      r_match_idx;
    logic [AW-1:0]      r_best_idx;
    logic [STAMP_W-1:0] r_best_stamp;
    logic               r_best_valid;
    logic [CODE_W-1:0]  r_best_tag;
    logic               first;
    logic               eq;
    logic               lt;

    always_comb begin
        first = (i_idx == '0);
        eq    = i_entry.valid && (i_entry.tag == i_code);
        lt    = (i_entry.stamp < r_best_stamp);
    end

    // first slot restarts both searches; strict less-than keeps the lowest tie
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (first || (!r_found && eq)) begin
                r_found     <= eq;
                r_match_idx <= i_idx;
            end
            if (first || lt) begin
                r_best_idx   <= i_idx;
                r_best_stamp <= i_entry.stamp;
                r_best_valid <= i_entry.valid;
                r_best_tag   <= i_entry.tag;
            end
        end
    end

    assign o_sum.found      = r_found;
    assign o_sum.best_valid = r_best_valid;
    assign o_sum.best_tag   = r_best_tag;
    assign o_match_idx      = r_match_idx;
    assign o_best_idx       = r_best_idx;

endmodule

FILE: sv/lru_glyph_slot_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_glyph_slot_cache_unit
// Fully associative glyph slot cache with timestamp LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the operation (get,
//   probe, remove), tdata the character code. Each request yields exactly one
//   response transaction on m_axis: hit, slot index, evicted flag and the
//   evicted code.
//   Every request scans all SLOTS entries through one compare unit, one slot
//   per cycle from the slot memory (one write port, one registered read
//   port). A request passes the scan, drain, update and response states
//   before its response enters the output register; the block takes no new
//   request until the sequencer is back in the idle state.
//   s_axis_tready is high only while the sequencer is idle.
//   After reset the block sweeps the slot memory to clear every entry, one
//   slot per cycle, with s_axis_tready low.
//   If the receiver stalls, the response is held in the output register and
//   the next request is still accepted; its own response waits in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module lru_glyph_slot_cache_unit
    import lgsc_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [15:0] char_code
    input  logic [1:0]        s_axis_tuser,   // [1:0] func
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // [0] hit, [6:1] slot_index,
                                              // [7] evicted, [23:8] evicted_char
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_cmp_vld;
    logic [AW-1:0]      r_cmp_idx;
    t_func              r_func;
    logic [CODE_W-1:0]  r_code;
    logic [STAMP_W-1:0] r_usage;
    logic [OUT_W-1:0]   r_res_data, n_res_data;
    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_data;

    logic               accept;
    logic               out_free;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_entry             mem_wdata;
    t_entry             mem_rdata;
    t_search            sum;
    logic [AW-1:0]      match_idx;
    logic [AW-1:0]      best_idx;
    logic               upd_we;
    logic [AW-1:0]      upd_addr;
    t_entry             upd_data;
    logic               bump_usage;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;

    lgsc_store #(.SLOTS(SLOTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    lgsc_search #(.SLOTS(SLOTS)) u_search (
        .i_clk       (i_clk),
        .i_en        (r_cmp_vld),
        .i_idx       (r_cmp_idx),
        .i_entry     (mem_rdata),
        .i_code      (r_code),
        .o_sum       (sum),
        .o_match_idx (match_idx),
        .o_best_idx  (best_idx)
    );

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // update decision: write back, response word, counter advance
    always_comb begin
        upd_we     = 1'b0;
        upd_addr   = match_idx;
        upd_data   = '0;
        bump_usage = 1'b0;
        n_res_data = '0;
        case (r_func)
            FUNC_GET: begin
                upd_we         = 1'b1;
                bump_usage     = 1'b1;
                upd_data.valid = 1'b1;
                upd_data.tag   = r_code;
                upd_data.stamp = r_usage;
                if (sum.found) begin
                    n_res_data[0]   = 1'b1;
                    n_res_data[6:1] = IDX_W'(match_idx);
                end else begin
                    upd_addr        = best_idx;
                    n_res_data[6:1] = IDX_W'(best_idx);
                    if (sum.best_valid) begin
                        n_res_data[7]    = 1'b1;
                        n_res_data[23:8] = sum.best_tag;
                    end
                end
            end
            FUNC_PROBE: begin
                if (sum.found) begin
                    n_res_data[0]   = 1'b1;
                    n_res_data[6:1] = IDX_W'(match_idx);
                end
            end
            FUNC_REMOVE: begin
                if (sum.found) begin
                    upd_we          = 1'b1;
                    n_res_data[0]   = 1'b1;
                    n_res_data[6:1] = IDX_W'(match_idx);
                end
            end
            default: begin
                upd_we = 1'b0;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        mem_we        = 1'b0;
        mem_waddr     = r_idx;
        mem_wdata     = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_UPDATE: begin
                mem_we    = upd_we;
                mem_waddr = upd_addr;
                mem_wdata = upd_data;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_usage   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            // read data lands in the cycle after the address
            r_cmp_vld <= (r_state == ST_SCAN);
            if (r_state == ST_UPDATE && bump_usage) begin
                r_usage <= r_usage + 1'b1;
            end
            if (r_state == ST_RESP && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (accept) begin
            r_func <= t_func'(s_axis_tuser);
            r_code <= s_axis_tdata;
        end
        if (r_state == ST_UPDATE) begin
            r_res_data <= n_res_data;
        end
        if (r_state == ST_RESP && out_free) begin
            r_m_data <= r_res_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: sv/lgsc_checker.sv
// ----------------------------------------------------------------------------
// lgsc_checker
// Port-level checks for the glyph slot cache, bound to the top level.
// ----------------------------------------------------------------------------
module lgsc_checker
    import lgsc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // hold a stalled response
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled response changed");

    // one request at a time: busy right after a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // eviction only on a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> !m_axis_tdata[0])
        else $error("eviction reported on a hit");

    // evicted code is zero without an eviction
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[23:8] == '0)
        else $error("evicted code without eviction");

    // reset drops both handshakes
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("handshake active after reset");

endmodule

bind lru_glyph_slot_cache_unit lgsc_checker u_lgsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
